/* src/ipss_pkg.sv */
// Package for the inverted-list probe size statistics block.
// Holds the item, command and result types, codes and the size-bin function.
// Depends on nothing; the front, back, checker and top-level files import it.
`default_nettype none

package ipss_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_PROBE  = 2'd1,
		OP_REPORT = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_PROBE  = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_REPORT = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CMD_PROBE  = 2'd0,
		CMD_ERROR  = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_code_t;

	localparam logic [3:0]  REPORT_DENOM = 4'd12;
	localparam logic [3:0]  REPORT_LAST  = 4'd14;
	localparam logic [32:0] PAD_ROUND    = 33'd31;
	localparam logic [47:0] BIN0_LIMIT   = 48'd256;
	localparam logic [47:0] BIN1_LIMIT   = 48'd1024;
	localparam logic [47:0] BIN2_LIMIT   = 48'd8192;
	localparam logic [12:0] LISTS_RESET  = 13'd1024;

	typedef struct packed {
		opcode_t     opcode;
		logic [11:0] list_index;
		logic [31:0] list_size;
		logic        last_probe_of_query;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [47:0] padded_value;
		logic [1:0]  size_bin;
		logic [3:0]  report_index;
		logic        last;
	} result_t;

	typedef struct packed {
		cmd_code_t   code;
		logic        drop;
		logic        closes;
		logic [31:0] size;
		logic [32:0] padded;
		logic [1:0]  bin;
	} cmd_t;

	function automatic logic [1:0] bin_of(input logic [47:0] v);
		logic [1:0] b;
		if (v < BIN0_LIMIT) begin
			b = 2'd0;
		end else if (v < BIN1_LIMIT) begin
			b = 2'd1;
		end else if (v < BIN2_LIMIT) begin
			b = 2'd2;
		end else begin
			b = 2'd3;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

/* src/ivf_probe_size_statistics.sv */
// Top level of the inverted-list probe size statistics block.
// Depends on ipss_pkg, ipss_front, ipss_fifo and ipss_back.
//
// Channel   Direction  Handshake           Payload
// item      in         push / full         item_t
// result    out        empty / pop         result_t
// config    in         APB, pready tied    lists_in_use at byte address 0
//
// Loads and probes are taken one per cycle unless full; a probe result goes
// via the stage register and middle queue to the result queue. The back part
// emits one result per cycle unless the result queue is full; a closing probe
// yields a probe and a query result. Reset clears statistics and queues; the
// size table is undefined until loaded. Either side may stall freely.
`default_nettype none

module ivf_probe_size_statistics
	import ipss_pkg::*;
#(
	parameter int MAX_LISTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire item_t       item,
	output logic             full,
	output logic             empty,
	input  wire logic        pop,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [12:0] lists_q;
	logic        mid_push;
	cmd_t        mid_cmd;
	logic        mid_full;
	logic        mid_empty;
	cmd_t        mid_head;
	logic        mid_pop;
	logic        res_push;
	result_t     res;
	logic        res_full;
	logic [$bits(result_t)-1:0] res_head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(lists_q) : '0;
	assign result = result_t'(res_head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_q <= LISTS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			lists_q <= pwdata[12:0];
		end
	end

	ipss_front #(
		.MAX_LISTS (MAX_LISTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.item         (item),
		.full         (full),
		.lists_in_use (lists_q),
		.mid_push     (mid_push),
		.mid_cmd      (mid_cmd),
		.mid_full     (mid_full)
	);

	ipss_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (4)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_cmd),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_head),
		.empty  (mid_empty)
	);

	ipss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mid_head),
		.cmd_valid (!mid_empty),
		.cmd_pop   (mid_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	ipss_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (4)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

endmodule

`default_nettype wire

/* src/ipss_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the list-size table.
`default_nettype none

module ipss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/ipss_fifo.sv */
// Small first-in first-out queue in flip-flops with full and empty flags.
// Stand-alone; used between the front and back parts and for the results.
`default_nettype none

module ipss_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/ipss_front.sv */
// Front part: accepts items, keeps the list-size table and classifies items.
// Depends on ipss_pkg and ipss_ram; hands commands to the queue before the back part.
`default_nettype none

module ipss_front
	import ipss_pkg::*;
#(
	parameter int MAX_LISTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire item_t       item,
	output logic             full,
	input  wire logic [12:0] lists_in_use,
	output logic             mid_push,
	output cmd_t             mid_cmd,
	input  wire logic        mid_full
);

	localparam int DEPTH = (MAX_LISTS < 4096) ? MAX_LISTS : 4096;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic        accept;
	logic        index_oor;
	logic        probe_err;
	logic        enter;
	logic [31:0] rdata;
	logic        valid_s1;
	cmd_code_t   code_s1;
	logic        closes_s1;
	logic        drop_s1;
	cmd_code_t   code_d;

	assign full      = valid_s1 && mid_full;
	assign accept    = push && !full;
	assign index_oor = (32'(item.list_index) >= 32'(MAX_LISTS));
	assign probe_err = index_oor || (13'(item.list_index) >= lists_in_use);
	assign enter     = accept && !(item.opcode == OP_LOAD && !index_oor);
	assign mid_push  = valid_s1 && !mid_full;

	always_comb begin
		unique case (item.opcode)
			OP_LOAD:   code_d = CMD_ERROR;
			OP_PROBE:  code_d = probe_err ? CMD_ERROR : CMD_PROBE;
			OP_REPORT: code_d = CMD_REPORT;
			OP_CLEAR:  code_d = CMD_CLEAR;
			default:   code_d = CMD_ERROR;
		endcase
	end

	ipss_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && item.opcode == OP_LOAD && !index_oor),
		.waddr (item.list_index[AW-1:0]),
		.wdata (item.list_size),
		.re    (accept && item.opcode == OP_PROBE),
		.raddr (item.list_index[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (enter) begin
			code_s1   <= code_d;
			closes_s1 <= item.last_probe_of_query;
			drop_s1   <= (item.opcode == OP_PROBE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enter) begin
			valid_s1 <= 1'b1;
		end else if (mid_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		mid_cmd.code   = code_s1;
		mid_cmd.drop   = drop_s1;
		mid_cmd.closes = closes_s1;
		mid_cmd.size   = rdata;
		mid_cmd.padded = ({1'b0, rdata} + PAD_ROUND) & ~PAD_ROUND;
		mid_cmd.bin    = bin_of(48'(rdata));
	end

endmodule

`default_nettype wire

/* src/ipss_back.sv */
// Back part: keeps the query totals and statistics and produces the results.
// Depends on ipss_pkg; takes middle-queue commands, one result per cycle unless res_full.
`default_nettype none

module ipss_back
	import ipss_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	output logic      res_push,
	output result_t   res,
	input  wire logic res_full
);

	logic [47:0] qt_q;
	logic [47:0] qpt_q;
	logic [31:0] qbin_q [4];
	logic [31:0] pbin_q [4];
	logic [63:0] wbin_q [4];
	logic [31:0] queries_q;
	logic [31:0] probes_q;
	logic [63:0] wtot_q;
	logic [3:0]  step_q;

	logic        go;
	logic [48:0] qt_sum;
	logic [48:0] qpt_sum;
	logic [64:0] wtot_sum;
	logic [64:0] wbin_sum [4];
	logic [1:0]  qbin;
	logic        do_probe;
	logic        do_query;
	logic        do_error;
	logic        do_clear;
	logic        do_report;

	assign go       = cmd_valid && !res_full;
	assign qt_sum   = {1'b0, qt_q} + 49'(cmd.size);
	assign qpt_sum  = {1'b0, qpt_q} + 49'(cmd.padded);
	assign wtot_sum = {1'b0, wtot_q} + 65'(cmd.size);
	assign qbin     = bin_of(qt_q);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			wbin_sum[i] = {1'b0, wbin_q[i]} + 65'(cmd.size);
		end
	end

	always_comb begin
		do_probe  = 1'b0;
		do_query  = 1'b0;
		do_error  = 1'b0;
		do_clear  = 1'b0;
		do_report = 1'b0;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		if (go) begin
			unique case (cmd.code)
				CMD_CLEAR: begin
					do_clear = 1'b1;
					cmd_pop  = 1'b1;
				end
				CMD_ERROR: begin
					do_error = cmd.drop;
					cmd_pop  = 1'b1;
					res_push = 1'b1;
					res.kind = KIND_ERROR;
					res.last = 1'b1;
				end
				CMD_PROBE: begin
					res_push = 1'b1;
					if (step_q == '0) begin
						do_probe         = 1'b1;
						cmd_pop          = !cmd.closes;
						res.kind         = KIND_PROBE;
						res.value        = 64'(cmd.size);
						res.padded_value = 48'(cmd.padded);
						res.size_bin     = cmd.bin;
						res.last         = !cmd.closes;
					end else begin
						do_query         = 1'b1;
						cmd_pop          = 1'b1;
						res.kind         = KIND_QUERY;
						res.value        = 64'(qt_q);
						res.padded_value = qpt_q;
						res.size_bin     = qbin;
						res.last         = 1'b1;
					end
				end
				CMD_REPORT: begin
					do_report        = 1'b1;
					res_push         = 1'b1;
					cmd_pop          = (step_q == REPORT_LAST);
					res.kind         = KIND_REPORT;
					res.report_index = step_q;
					res.size_bin     = (step_q < REPORT_DENOM) ? step_q[1:0] : 2'd0;
					res.last         = (step_q == REPORT_LAST);
					unique case (step_q)
						4'd0:    res.value = 64'(qbin_q[0]);
						4'd1:    res.value = 64'(qbin_q[1]);
						4'd2:    res.value = 64'(qbin_q[2]);
						4'd3:    res.value = 64'(qbin_q[3]);
						4'd4:    res.value = 64'(pbin_q[0]);
						4'd5:    res.value = 64'(pbin_q[1]);
						4'd6:    res.value = 64'(pbin_q[2]);
						4'd7:    res.value = 64'(pbin_q[3]);
						4'd8:    res.value = wbin_q[0];
						4'd9:    res.value = wbin_q[1];
						4'd10:   res.value = wbin_q[2];
						4'd11:   res.value = wbin_q[3];
						4'd12:   res.value = 64'(queries_q);
						4'd13:   res.value = 64'(probes_q);
						4'd14:   res.value = wtot_q;
						default: res.value = '0;
					endcase
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qt_q      <= '0;
			qpt_q     <= '0;
			queries_q <= '0;
			probes_q  <= '0;
			wtot_q    <= '0;
			step_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				qbin_q[i] <= '0;
				pbin_q[i] <= '0;
				wbin_q[i] <= '0;
			end
		end else begin
			if (do_clear) begin
				qt_q      <= '0;
				qpt_q     <= '0;
				queries_q <= '0;
				probes_q  <= '0;
				wtot_q    <= '0;
				for (int i = 0; i < 4; i++) begin
					qbin_q[i] <= '0;
					pbin_q[i] <= '0;
					wbin_q[i] <= '0;
				end
			end
			if (do_error) begin
				qt_q  <= '0;
				qpt_q <= '0;
			end
			if (do_probe) begin
				qt_q     <= qt_sum[48] ? '1 : qt_sum[47:0];
				qpt_q    <= qpt_sum[48] ? '1 : qpt_sum[47:0];
				probes_q <= (probes_q == '1) ? probes_q : probes_q + 1'b1;
				wtot_q   <= wtot_sum[64] ? '1 : wtot_sum[63:0];
				for (int i = 0; i < 4; i++) begin
					if (cmd.bin == 2'(i)) begin
						pbin_q[i] <= (pbin_q[i] == '1) ? pbin_q[i] : pbin_q[i] + 1'b1;
						wbin_q[i] <= wbin_sum[i][64] ? '1 : wbin_sum[i][63:0];
					end
				end
				if (cmd.closes) begin
					step_q <= 4'd1;
				end
			end
			if (do_query) begin
				qt_q      <= '0;
				qpt_q     <= '0;
				queries_q <= (queries_q == '1) ? queries_q : queries_q + 1'b1;
				step_q    <= '0;
				for (int i = 0; i < 4; i++) begin
					if (qbin == 2'(i)) begin
						qbin_q[i] <= (qbin_q[i] == '1) ? qbin_q[i] : qbin_q[i] + 1'b1;
					end
				end
			end
			if (do_report) begin
				step_q <= (step_q == REPORT_LAST) ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/ipss_checker.sv */
// Port-level checks for the probe size statistics block, bound to its top level.
// Depends on ipss_pkg and on the ports of ivf_probe_size_statistics.
`default_nettype none

module ipss_checker
	import ipss_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    empty,
	input wire logic    pop,
	input wire result_t result
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("A waiting result changed before its transfer.");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == KIND_ERROR |-> result.last && result.value == '0
			&& result.padded_value == '0 && result.size_bin == '0
			&& result.report_index == '0)
		else $error("An error result carries nonzero fields or lacks last.");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == KIND_REPORT |->
			result.last == (result.report_index == REPORT_LAST))
		else $error("A report word has last on the wrong index.");

	a_probe_padding: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.kind == KIND_PROBE |-> result.padded_value[4:0] == 5'd0
			&& result.value[63:32] == '0
			&& result.padded_value >= result.value[47:0]
			&& result.size_bin == bin_of(result.value[47:0]))
		else $error("A probe result has an inconsistent padded size or bin.");

endmodule

bind ivf_probe_size_statistics ipss_checker u_checker (.*);

`default_nettype wire
